[rtl/core/vrabu_pkg.sv]
// Shared types and constants for the CHIP-8 register, ALU and branch unit.
package vrabu_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned STACK_IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned LEVEL_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RESET_PC    = 512;

  localparam int unsigned GP_COUNT = 16;

  localparam logic [15:0] RET_WORD = 16'h00EE;
  localparam logic [3:0]  FLAG_IDX = 4'hF;
  localparam logic [11:0] PC_STEP  = 12'd2;

  typedef enum logic [3:0] {
    OP_SYS     = 4'h0,
    OP_JP      = 4'h1,
    OP_CALL    = 4'h2,
    OP_SE_IMM  = 4'h3,
    OP_SNE_IMM = 4'h4,
    OP_SE_REG  = 4'h5,
    OP_LD_IMM  = 4'h6,
    OP_ADD_IMM = 4'h7,
    OP_ALU     = 4'h8,
    OP_SNE_REG = 4'h9,
    OP_LD_I    = 4'hA,
    OP_JP_V0   = 4'hB,
    OP_RND     = 4'hC,
    OP_DRW     = 4'hD,
    OP_KEY     = 4'hE,
    OP_MISC    = 4'hF
  } op_t;

  typedef enum logic [3:0] {
    ALU_LD   = 4'h0,
    ALU_OR   = 4'h1,
    ALU_AND  = 4'h2,
    ALU_XOR  = 4'h3,
    ALU_ADD  = 4'h4,
    ALU_SUB  = 4'h5,
    ALU_SHR  = 4'h6,
    ALU_SUBN = 4'h7,
    ALU_SHL  = 4'hE
  } alu_t;

  // Register file write-back from the execute stage.
  typedef struct packed {
    logic       gp_we;
    logic       flag_we;
    logic [3:0] x;
    logic [7:0] gp_data;
    logic [7:0] flag_data;
  } wb_t;

  // Return stack request from the execute stage.
  typedef struct packed {
    logic        push;
    logic        pop;
    logic [11:0] push_addr;
  } stk_t;

endpackage

[rtl/core/vrabu_regfile.sv]
// General register file V0..VE with registered reads and write bypass, plus the VF flag register.
module vrabu_regfile
  import vrabu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rd_en,
  input  logic [3:0] rd_x_addr,
  input  logic [3:0] rd_y_addr,
  input  wb_t        wb,
  output logic [7:0] rd_x,
  output logic [7:0] rd_y,
  output logic [7:0] rd_v0,
  output logic [7:0] flag
);

  logic [7:0]          gp [GP_COUNT];
  logic [GP_COUNT-1:0] gp_valid;
  logic [7:0]          flag_next;
  logic                gp_wr;
  logic                x_hit;
  logic                y_hit;
  logic                v0_hit;

  // A write to VF as the destination replaces the flag written by the same instruction.
  always_comb begin
    flag_next = flag;
    if (wb.gp_we && (wb.x == FLAG_IDX)) begin
      flag_next = wb.gp_data;
    end else if (wb.flag_we) begin
      flag_next = wb.flag_data;
    end
  end

  assign gp_wr  = wb.gp_we && (wb.x != FLAG_IDX);
  assign x_hit  = gp_wr && (wb.x == rd_x_addr);
  assign y_hit  = gp_wr && (wb.x == rd_y_addr);
  assign v0_hit = gp_wr && (wb.x == 4'h0);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag     <= 8'h00;
      gp_valid <= '0;
    end else begin
      flag <= flag_next;
      if (gp_wr) begin
        gp_valid[wb.x] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gp_wr) begin
      gp[wb.x] <= wb.gp_data;
    end
  end

  // Reads are taken as the instruction enters, with the executing instruction's write forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_x_addr == FLAG_IDX) begin
        rd_x <= flag_next;
      end else if (x_hit) begin
        rd_x <= wb.gp_data;
      end else begin
        rd_x <= gp_valid[rd_x_addr] ? gp[rd_x_addr] : 8'h00;
      end
      if (rd_y_addr == FLAG_IDX) begin
        rd_y <= flag_next;
      end else if (y_hit) begin
        rd_y <= wb.gp_data;
      end else begin
        rd_y <= gp_valid[rd_y_addr] ? gp[rd_y_addr] : 8'h00;
      end
      if (v0_hit) begin
        rd_v0 <= wb.gp_data;
      end else begin
        rd_v0 <= gp_valid[0] ? gp[0] : 8'h00;
      end
    end
  end

endmodule

[rtl/core/vrabu_stack.sv]
// Return stack of call addresses with its fill level.
module vrabu_stack
  import vrabu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stk_t        req,
  output logic        full,
  output logic        empty,
  output logic [11:0] top
);

  logic [11:0]        entries [STACK_DEPTH];
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_m1;

  assign full     = (level >= LEVEL_W'(STACK_DEPTH));
  assign empty    = (level == '0);
  assign level_m1 = level - LEVEL_W'(1);
  assign top      = entries[level_m1[STACK_IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (req.push && !full) begin
      level <= level + LEVEL_W'(1);
    end else if (req.pop && !empty) begin
      level <= level_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push && !full) begin
      entries[level[STACK_IDX_W-1:0]] <= req.push_addr;
    end
  end

`ifndef NO_ASSERTIONS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(STACK_DEPTH))
    else $error("return stack level beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    req.push && !full |=> level == $past(level) + LEVEL_W'(1))
    else $error("push did not raise the stack level");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    req.pop && !req.push && !empty |=> level == $past(level) - LEVEL_W'(1))
    else $error("pop did not lower the stack level");
`endif

endmodule

[rtl/core/vrabu_exec.sv]
// Instruction decode, 8-bit ALU and next-counter selection for one instruction.
module vrabu_exec
  import vrabu_pkg::*;
(
  input  logic [15:0] instr,
  input  logic [7:0]  rnd,
  input  logic [7:0]  vx,
  input  logic [7:0]  vy,
  input  logic [7:0]  v0,
  input  logic [7:0]  vf,
  input  logic [11:0] pc,
  input  logic        stk_full,
  input  logic        stk_empty,
  input  logic [11:0] stk_top,
  output logic [11:0] pc_next,
  output logic        index_we,
  output logic [11:0] index_next,
  output wb_t         wb,
  output stk_t        stk,
  output logic [7:0]  vf_after,
  output logic        skip,
  output logic        fault,
  output logic        unsup
);

  logic [3:0]  n;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [11:0] pc_plus;
  logic [11:0] target;
  logic [8:0]  sum;

  assign n       = instr[3:0];
  assign kk      = instr[7:0];
  assign nnn     = instr[11:0];
  assign pc_plus = pc + PC_STEP;
  assign sum     = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    target         = pc_plus;
    skip           = 1'b0;
    fault          = 1'b0;
    unsup          = 1'b0;
    index_we       = 1'b0;
    index_next     = nnn;
    wb             = '0;
    wb.x           = instr[11:8];
    stk            = '0;
    stk.push_addr  = pc_plus;
    case (op_t'(instr[15:12]))
      OP_SYS: begin
        if (instr == RET_WORD) begin
          if (stk_empty) begin
            fault = 1'b1;
          end else begin
            stk.pop = 1'b1;
            target  = stk_top;
          end
        end else begin
          unsup = 1'b1;
        end
      end
      OP_JP: begin
        target = nnn;
      end
      OP_CALL: begin
        if (stk_full) begin
          fault = 1'b1;
        end else begin
          stk.push = 1'b1;
          target   = nnn;
        end
      end
      OP_SE_IMM: begin
        skip = (vx == kk);
      end
      OP_SNE_IMM: begin
        skip = (vx != kk);
      end
      OP_SE_REG: begin
        if (n == 4'h0) begin
          skip = (vx == vy);
        end else begin
          unsup = 1'b1;
        end
      end
      OP_LD_IMM: begin
        wb.gp_we   = 1'b1;
        wb.gp_data = kk;
      end
      OP_ADD_IMM: begin
        wb.gp_we   = 1'b1;
        wb.gp_data = vx + kk;
      end
      OP_ALU: begin
        wb.gp_we = 1'b1;
        case (alu_t'(n))
          ALU_LD:  wb.gp_data = vy;
          ALU_OR:  wb.gp_data = vx | vy;
          ALU_AND: wb.gp_data = vx & vy;
          ALU_XOR: wb.gp_data = vx ^ vy;
          ALU_ADD: begin
            wb.flag_we   = 1'b1;
            wb.flag_data = {7'd0, sum[8]};
            wb.gp_data   = sum[7:0];
          end
          ALU_SUB: begin
            wb.flag_we   = 1'b1;
            wb.flag_data = {7'd0, (vx > vy)};
            wb.gp_data   = vx - vy;
          end
          ALU_SHR: begin
            wb.flag_we   = 1'b1;
            wb.flag_data = {7'd0, vx[0]};
            wb.gp_data   = {1'b0, vx[7:1]};
          end
          ALU_SUBN: begin
            wb.flag_we   = 1'b1;
            wb.flag_data = {7'd0, (vy > vx)};
            wb.gp_data   = vy - vx;
          end
          ALU_SHL: begin
            wb.flag_we   = 1'b1;
            wb.flag_data = {7'd0, vx[7]};
            wb.gp_data   = {vx[6:0], 1'b0};
          end
          default: begin
            wb.gp_we = 1'b0;
            unsup    = 1'b1;
          end
        endcase
      end
      OP_SNE_REG: begin
        if (n == 4'h0) begin
          skip = (vx != vy);
        end else begin
          unsup = 1'b1;
        end
      end
      OP_LD_I: begin
        index_we = 1'b1;
      end
      OP_JP_V0: begin
        target = nnn + {4'd0, v0};
      end
      OP_RND: begin
        wb.gp_we   = 1'b1;
        wb.gp_data = rnd & kk;
      end
      default: begin
        unsup = 1'b1;
      end
    endcase
    pc_next = skip ? (target + PC_STEP) : target;
  end

  always_comb begin
    vf_after = vf;
    if (wb.gp_we && (wb.x == FLAG_IDX)) begin
      vf_after = wb.gp_data;
    end else if (wb.flag_we) begin
      vf_after = wb.flag_data;
    end
  end

endmodule

[rtl/core/vm_register_alu_branch_unit.sv]
// Top level of the CHIP-8 instruction execute unit.
// One instruction is taken per cycle and its result is registered once the result register
// can take it: the input register also captures Vx, Vy and V0 from the register file, with
// the write of the instruction then executing forwarded, and a single pass of decode, 8-bit
// ALU and counter selection fills the result register while the state is updated. A held
// result stalls the input only once the input register is also full, so with no output stall
// the sustained rate is one instruction per cycle. Reset leaves V0..VF and the index register
// at zero, the counter at 512 and the return stack empty; no clearing pass is needed.
module vm_register_alu_branch_unit
  import vrabu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] instr_word,
  input  logic [7:0]  rand_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] next_pc,
  output logic [11:0] index_value,
  output logic [7:0]  flag_reg_value,
  output logic        skip_taken,
  output logic        stack_fault,
  output logic        unsupported_op
);

  logic        s1_valid;
  logic [15:0] s1_instr;
  logic [7:0]  s1_rand;
  logic        load;
  logic        fire;

  logic [11:0] pc;
  logic [11:0] index_reg;

  logic [7:0]  vx;
  logic [7:0]  vy;
  logic [7:0]  v0;
  logic [7:0]  vf;

  logic        stk_full;
  logic        stk_empty;
  logic [11:0] stk_top;

  logic [11:0] ex_pc_next;
  logic        ex_index_we;
  logic [11:0] ex_index_next;
  wb_t         ex_wb;
  stk_t        ex_stk;
  logic [7:0]  ex_vf_after;
  logic        ex_skip;
  logic        ex_fault;
  logic        ex_unsup;

  wb_t         wb;
  stk_t        stk_req;

  assign in_stall = s1_valid && out_valid && out_stall;
  assign load     = in_valid && !in_stall;
  assign fire     = s1_valid && !(out_valid && out_stall);

  // State changes only when the executing instruction moves into the result register.
  assign wb      = fire ? ex_wb  : '0;
  assign stk_req = fire ? ex_stk : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_instr <= instr_word;
      s1_rand  <= rand_byte;
    end
  end

  vrabu_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (load),
    .rd_x_addr (instr_word[11:8]),
    .rd_y_addr (instr_word[7:4]),
    .wb        (wb),
    .rd_x      (vx),
    .rd_y      (vy),
    .rd_v0     (v0),
    .flag      (vf)
  );

  vrabu_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .req   (stk_req),
    .full  (stk_full),
    .empty (stk_empty),
    .top   (stk_top)
  );

  vrabu_exec u_exec (
    .instr      (s1_instr),
    .rnd        (s1_rand),
    .vx         (vx),
    .vy         (vy),
    .v0         (v0),
    .vf         (vf),
    .pc         (pc),
    .stk_full   (stk_full),
    .stk_empty  (stk_empty),
    .stk_top    (stk_top),
    .pc_next    (ex_pc_next),
    .index_we   (ex_index_we),
    .index_next (ex_index_next),
    .wb         (ex_wb),
    .stk        (ex_stk),
    .vf_after   (ex_vf_after),
    .skip       (ex_skip),
    .fault      (ex_fault),
    .unsup      (ex_unsup)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= RESET_PC[11:0];
      index_reg <= 12'd0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        pc        <= ex_pc_next;
        out_valid <= 1'b1;
        if (ex_index_we) begin
          index_reg <= ex_index_next;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      next_pc        <= ex_pc_next;
      index_value    <= ex_index_we ? ex_index_next : index_reg;
      flag_reg_value <= ex_vf_after;
      skip_taken     <= ex_skip;
      stack_fault    <= ex_fault;
      unsupported_op <= ex_unsup;
    end
  end

`ifndef NO_ASSERTIONS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(stack_fault && unsupported_op) && !(skip_taken && stack_fault))
    else $error("result carries contradictory status flags");

  a_pc_tracks_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> next_pc == pc)
    else $error("result counter differs from the architectural counter");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !fire |=> s1_valid && $stable(s1_instr))
    else $error("input register lost a waiting instruction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !fire |-> !load)
    else $error("transfer accepted over a waiting instruction");
`endif

endmodule
